[design/btm_pkg.sv]
// Shared types, codes and helper functions of the breakpoint table manager.
package btm_pkg;

	localparam int TABLE_DEPTH_DEF = 8;
	localparam int ADDR_W          = 16;
	localparam int COUNT_W         = 4;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic              active;
		logic              stored;
	} bp_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND_RD,
		ST_FIND_EV,
		ST_CLR_RD,
		ST_CLR_EV,
		ST_SRT_RD,
		ST_SRT_HOLD,
		ST_SRT_CMP_RD,
		ST_SRT_CMP_EV,
		ST_TRM_RD,
		ST_TRM_EV,
		ST_CMT_RD,
		ST_CMT_EV,
		ST_RESP
	} state_t;

	// An entry is live when it is wanted or still planted.
	function automatic logic is_live(input bp_entry_t e);
		return e.active | e.stored;
	endfunction

	// True when entry k must move behind the held entry during the sort.
	function automatic logic goes_after(input bp_entry_t k, input bp_entry_t h);
		logic k_live;
		logic h_live;
		k_live = is_live(k);
		h_live = is_live(h);
		if (!k_live && !h_live) return 1'b0;
		if (!k_live) return 1'b1;
		if (!h_live) return 1'b0;
		return k.address > h.address;
	endfunction

endpackage

[design/btm_if.sv]
// Command and response channel interfaces of the breakpoint table manager.
interface btm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] flash_addr;

	modport source (output valid, output opcode, output flash_addr, input ready);
	modport sink   (input valid, input opcode, input flash_addr, output ready);
endinterface

interface btm_rsp_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [3:0] entries_used;
	logic [3:0] entries_changed;

	modport source (output valid, output ok, output entries_used, output entries_changed,
		input ready);
	modport sink   (input valid, input ok, input entries_used, input entries_changed,
		output ready);
endinterface

[design/btm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module btm_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[design/breakpoint_table_manager.sv]
// Breakpoint table manager: sequencer over a table RAM for add, remove, clear and flush.
//
// Usage: a command word (opcode, flash_addr) enters on the cmd channel and exactly one
// response word (ok, entries_used, entries_changed) leaves on the rsp channel. The block
// takes one command at a time: cmd.ready is high only while the sequencer is idle.
// All work goes through one table RAM with a single write port and a registered read
// port, so every visited entry takes a read state (address out) and an evaluate state
// (data back). Add and remove search the entries in order until a hit or the last entry
// in use; clear visits every entry in use; flush runs an insertion sort over the entries,
// then trims dead entries off the tail, then commits every entry that remains.
// The response sits in an output register; the next command is accepted while it waits.
// If rsp stalls, a finished second command waits in its last state until the register
// frees up, and no further command is taken.
// Reset clears the entry count and the response valid flag. Table contents are not
// cleared: only entries below the count are ever used.
module breakpoint_table_manager #(
	parameter int TABLE_DEPTH = btm_pkg::TABLE_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	btm_cmd_if.sink  cmd,
	btm_rsp_if.source rsp
);

	import btm_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int EW = $bits(bp_entry_t);

	state_t            state_q, state_d;
	logic [CW-1:0]     used_q, used_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     j_q, j_d;
	logic [CW-1:0]     chg_q, chg_d;
	logic              ok_q, ok_d;
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	bp_entry_t         hold_q;
	logic              hold_load;
	logic              cmd_take;

	logic              rsp_valid_q;
	logic              rsp_ok_q;
	logic [COUNT_W-1:0] rsp_used_q;
	logic [COUNT_W-1:0] rsp_chg_q;
	logic              rsp_load;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	bp_entry_t         wr_data;
	logic [AW-1:0]     rd_addr;
	logic [EW-1:0]     rd_raw;
	bp_entry_t         rd_data;

	logic [CW-1:0]     used_m1;
	logic [CW-1:0]     j_m1;
	logic [WW-1:0]     used_wide;
	logic [WW-1:0]     chg_wide;

	assign rd_data   = bp_entry_t'(rd_raw);
	assign used_m1   = used_q - 1'b1;
	assign j_m1      = j_q - 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;

	btm_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// Sequencer: each entry visit is a read state followed by an evaluate state.
	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		idx_d     = idx_q;
		j_d       = j_q;
		chg_d     = chg_q;
		ok_d      = ok_q;
		hold_load = 1'b0;
		rsp_load  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = idx_q[AW-1:0];
		wr_data   = rd_data;
		rd_addr   = idx_q[AW-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					idx_d = '0;
					chg_d = '0;
					ok_d  = 1'b1;
					unique case (op_t'(cmd.opcode))
						OP_ADD, OP_REMOVE: state_d = ST_FIND_RD;
						OP_CLEAR:          state_d = ST_CLR_RD;
						OP_FLUSH: begin
							idx_d   = CW'(1);
							state_d = ST_SRT_RD;
						end
						default:           state_d = ST_IDLE;
					endcase
				end
			end

			ST_FIND_RD: begin
				if (idx_q >= used_q) begin
					// No match: add appends a new entry if there is room.
					if (op_q == OP_ADD && used_q < CW'(TABLE_DEPTH)) begin
						wr_en   = 1'b1;
						wr_addr = used_q[AW-1:0];
						wr_data = '{address: addr_q, active: 1'b1, stored: 1'b0};
						used_d  = used_q + 1'b1;
					end else begin
						ok_d = 1'b0;
					end
					state_d = ST_RESP;
				end else begin
					state_d = ST_FIND_EV;
				end
			end

			ST_FIND_EV: begin
				if (rd_data.address == addr_q) begin
					wr_en          = 1'b1;
					wr_data.active = (op_q == OP_ADD);
					state_d        = ST_RESP;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_FIND_RD;
				end
			end

			ST_CLR_RD: begin
				state_d = (idx_q >= used_q) ? ST_RESP : ST_CLR_EV;
			end

			ST_CLR_EV: begin
				wr_en          = 1'b1;
				wr_data.active = 1'b0;
				idx_d          = idx_q + 1'b1;
				state_d        = ST_CLR_RD;
			end

			ST_SRT_RD: begin
				state_d = (idx_q >= used_q) ? ST_TRM_RD : ST_SRT_HOLD;
			end

			ST_SRT_HOLD: begin
				hold_load = 1'b1;
				j_d       = idx_q;
				state_d   = ST_SRT_CMP_RD;
			end

			ST_SRT_CMP_RD: begin
				rd_addr = j_m1[AW-1:0];
				if (j_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = j_q[AW-1:0];
					wr_data = hold_q;
					idx_d   = idx_q + 1'b1;
					state_d = ST_SRT_RD;
				end else begin
					state_d = ST_SRT_CMP_EV;
				end
			end

			ST_SRT_CMP_EV: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				if (goes_after(rd_data, hold_q)) begin
					// Shift the entry that goes after the held one up one place and keep looking down.
					wr_data = rd_data;
					j_d     = j_m1;
					state_d = ST_SRT_CMP_RD;
				end else begin
					wr_data = hold_q;
					idx_d   = idx_q + 1'b1;
					state_d = ST_SRT_RD;
				end
			end

			ST_TRM_RD: begin
				rd_addr = used_m1[AW-1:0];
				if (used_q == '0) begin
					idx_d   = '0;
					state_d = ST_CMT_RD;
				end else begin
					state_d = ST_TRM_EV;
				end
			end

			ST_TRM_EV: begin
				if (is_live(rd_data)) begin
					idx_d   = '0;
					state_d = ST_CMT_RD;
				end else begin
					used_d  = used_m1;
					state_d = ST_TRM_RD;
				end
			end

			ST_CMT_RD: begin
				state_d = (idx_q >= used_q) ? ST_RESP : ST_CMT_EV;
			end

			ST_CMT_EV: begin
				if (rd_data.active != rd_data.stored) begin
					chg_d = chg_q + 1'b1;
				end
				wr_en          = 1'b1;
				wr_data.stored = rd_data.active;
				idx_d          = idx_q + 1'b1;
				state_d        = ST_CMT_RD;
			end

			ST_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			idx_q       <= '0;
			j_q         <= '0;
			chg_q       <= '0;
			ok_q        <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			idx_q   <= idx_d;
			j_q     <= j_d;
			chg_q   <= chg_d;
			ok_q    <= ok_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign used_wide = WW'(used_q);
	assign chg_wide  = WW'(chg_q);

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			op_q   <= op_t'(cmd.opcode);
			addr_q <= cmd.flash_addr;
		end
		if (hold_load) begin
			hold_q <= rd_data;
		end
		if (rsp_load) begin
			rsp_ok_q   <= ok_q;
			rsp_used_q <= used_wide[COUNT_W-1:0];
			rsp_chg_q  <= chg_wide[COUNT_W-1:0];
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.ok              = rsp_ok_q;
	assign rsp.entries_used    = rsp_used_q;
	assign rsp.entries_changed = rsp_chg_q;

endmodule

[tb/tb_breakpoint_table_manager.sv]
// Self-checking testbench for the breakpoint table manager: directed table plus random words.
module tb_breakpoint_table_manager;
	import btm_pkg::*;

	localparam int DEPTH           = TABLE_DEPTH_DEF;
	localparam int RANDOM_WORDS    = 1600;
	localparam int POOL_SIZE       = 12;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_CYCLES    = 120;
	localparam int WATCHDOG_CYCLES = 1_000_000;

	// One response word as the block reports it.
	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] used;
		logic [COUNT_W-1:0] changed;
	} rsp_word_t;

	// One row of the directed table. When typed_in is set, the response is the one written
	// in the row; otherwise the table mirror below works it out.
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic              typed_in;
		rsp_word_t         want;
	} step_row_t;

	localparam int ROWS = 27;

	// The first rows fill the table to the brim, probe both address extremes, re-add while
	// full and commit everything. The later rows walk a stored-but-inactive entry through
	// its restore and its trim, and finish with the single-entry flush.
	localparam step_row_t DIRECTED_ROWS [ROWS] = '{
		'{OP_FLUSH,  16'h0000, 1'b1, '{1'b1, 4'd0, 4'd0}},
		'{OP_REMOVE, 16'h0000, 1'b1, '{1'b0, 4'd0, 4'd0}},
		'{OP_CLEAR,  16'h0000, 1'b1, '{1'b1, 4'd0, 4'd0}},
		'{OP_ADD,    16'h0000, 1'b1, '{1'b1, 4'd1, 4'd0}},
		'{OP_ADD,    16'hFFFF, 1'b1, '{1'b1, 4'd2, 4'd0}},
		'{OP_ADD,    16'hFFFF, 1'b1, '{1'b1, 4'd2, 4'd0}},
		'{OP_ADD,    16'h8000, 1'b1, '{1'b1, 4'd3, 4'd0}},
		'{OP_ADD,    16'h7FFF, 1'b1, '{1'b1, 4'd4, 4'd0}},
		'{OP_ADD,    16'h5555, 1'b1, '{1'b1, 4'd5, 4'd0}},
		'{OP_ADD,    16'hAAAA, 1'b1, '{1'b1, 4'd6, 4'd0}},
		'{OP_ADD,    16'h0001, 1'b1, '{1'b1, 4'd7, 4'd0}},
		'{OP_ADD,    16'hFFFE, 1'b1, '{1'b1, 4'd8, 4'd0}},
		'{OP_ADD,    16'h1234, 1'b1, '{1'b0, 4'd8, 4'd0}},
		'{OP_ADD,    16'h5555, 1'b1, '{1'b1, 4'd8, 4'd0}},
		'{OP_FLUSH,  16'h0000, 1'b1, '{1'b1, 4'd8, 4'd8}},
		'{OP_REMOVE, 16'hFFFF, 1'b0, '0},
		'{OP_REMOVE, 16'hFFFF, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_CLEAR,  16'h0000, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_ADD,    16'h00FF, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_REMOVE, 16'h00FF, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0},
		'{OP_FLUSH,  16'h0000, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	btm_cmd_if cmd_ch ();
	btm_rsp_if rsp_ch ();

	breakpoint_table_manager u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Mirror of the breakpoint table. Entries at or above bp_count are never read, so their
	// starting contents do not matter.
	logic [ADDR_W-1:0] bp_addr   [DEPTH];
	logic              bp_active [DEPTH];
	logic              bp_stored [DEPTH];
	int                bp_count = 0;

	// Response words owed by the block, oldest first.
	rsp_word_t response_words_due [$];

	int  mismatches    = 0;
	int  burst_left    = 0;
	bit  hold_off_req  = 1'b0;

	// Index of the first entry that carries the address, or -1 when none does.
	function automatic int locate_entry(input logic [ADDR_W-1:0] a);
		for (int k = 0; k < bp_count; k++) begin
			if (bp_addr[k] == a) begin
				return k;
			end
		end
		return -1;
	endfunction

	// Applies one command word to the mirror and returns the response it must produce.
	function automatic rsp_word_t table_execute(input op_t op, input logic [ADDR_W-1:0] a);
		rsp_word_t         r;
		int                k;
		int                j;
		int                diffs;
		logic [ADDR_W-1:0] ha;
		logic              hact;
		logic              hsto;
		logic              h_live;
		logic              k_live;
		r.ok  = 1'b1;
		diffs = 0;
		case (op)
			OP_ADD: begin
				// A known address is only reactivated; its stored flag stays as it is.
				k = locate_entry(a);
				if (k >= 0) begin
					bp_active[k] = 1'b1;
				end else if (bp_count >= DEPTH) begin
					r.ok = 1'b0;
				end else begin
					bp_addr[bp_count]   = a;
					bp_active[bp_count] = 1'b1;
					bp_stored[bp_count] = 1'b0;
					bp_count++;
				end
			end
			OP_REMOVE: begin
				k = locate_entry(a);
				if (k >= 0) begin
					bp_active[k] = 1'b0;
				end else begin
					r.ok = 1'b0;
				end
			end
			OP_CLEAR: begin
				for (k = 0; k < bp_count; k++) begin
					bp_active[k] = 1'b0;
				end
			end
			default: begin
				// Stable insertion sort: dead entries sink to the end, live ones go in
				// ascending address order.
				for (k = 1; k < bp_count; k++) begin
					ha     = bp_addr[k];
					hact   = bp_active[k];
					hsto   = bp_stored[k];
					h_live = hact | hsto;
					j      = k;
					while (j > 0) begin
						k_live = bp_active[j-1] | bp_stored[j-1];
						if (!(k_live ? (h_live && bp_addr[j-1] > ha) : h_live)) begin
							break;
						end
						bp_addr[j]   = bp_addr[j-1];
						bp_active[j] = bp_active[j-1];
						bp_stored[j] = bp_stored[j-1];
						j--;
					end
					bp_addr[j]   = ha;
					bp_active[j] = hact;
					bp_stored[j] = hsto;
				end
				// Trim the dead tail before committing, so an entry that is being restored
				// right now survives this flush.
				while (bp_count > 0 && !(bp_active[bp_count-1] | bp_stored[bp_count-1])) begin
					bp_count--;
				end
				for (k = 0; k < bp_count; k++) begin
					if (bp_active[k] != bp_stored[k]) begin
						diffs++;
					end
					bp_stored[k] = bp_active[k];
				end
			end
		endcase
		r.used    = bp_count[COUNT_W-1:0];
		r.changed = diffs[COUNT_W-1:0];
		return r;
	endfunction

	// Offers one command word, with the burst and gap pattern of the sender folded in. The
	// word is accepted at the rising edge where ready is seen high; at that point the
	// response it owes is queued.
	task automatic offer_word(input op_t op, input logic [ADDR_W-1:0] a,
			input logic typed_in, input rsp_word_t want);
		int        gap;
		rsp_word_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.opcode     <= op;
		cmd_ch.flash_addr <= a;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		predicted = table_execute(op, a);
		response_words_due.push_back(typed_in ? want : predicted);
	endtask

	// Stops offering and waits until every owed response word has been taken.
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		burst_left = 0;
		while (response_words_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Response side: segments of free flow, light stalls and heavy stalls. On request it
	// holds ready low for a long stretch, so that the output register and the finished
	// second command back up and the command channel stalls.
	initial begin : rsp_pacing
		int mode;
		int span;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end
			mode = $urandom_range(0, 2);
			span = $urandom_range(8, 64);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0:       rsp_ch.ready <= 1'b1;
					1:       rsp_ch.ready <= ($urandom_range(0, 99) >= 40);
					default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Every response word taken is compared field by field with the oldest one owed.
	always @(posedge clk) begin : response_check
		rsp_word_t seen;
		rsp_word_t due;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			seen = '{rsp_ch.ok, rsp_ch.entries_used, rsp_ch.entries_changed};
			if (response_words_due.size() == 0) begin
				$display("%0t: response word with none owed: ok=%0b used=%0d changed=%0d",
					$time, seen.ok, seen.used, seen.changed);
				mismatches++;
			end else begin
				due = response_words_due.pop_front();
				if (seen.ok !== due.ok) begin
					$display("%0t: ok expected %0b, got %0b", $time, due.ok, seen.ok);
					mismatches++;
				end
				if (seen.used !== due.used) begin
					$display("%0t: entries_used expected %0d, got %0d",
						$time, due.used, seen.used);
					mismatches++;
				end
				if (seen.changed !== due.changed) begin
					$display("%0t: entries_changed expected %0d, got %0d",
						$time, due.changed, seen.changed);
					mismatches++;
				end
			end
		end
	end

	// A hung handshake must not keep the run alive forever.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < WATCHDOG_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("breakpoint_table_manager verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
		logic [ADDR_W-1:0] a;
		op_t               op;
		int                roll;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.opcode     <= OP_ADD;
		cmd_ch.flash_addr <= '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			offer_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].addr,
				DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].want);
		end

		// Most addresses come from a small pool that is refreshed now and then, so adds
		// hit existing entries, removes find their target and the table keeps filling up.
		// The rest are drawn over the whole 16-bit range.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) begin
				for (int p = 0; p < POOL_SIZE; p++) begin
					addr_pool[p] = ADDR_W'($urandom_range(0, 65535));
				end
			end
			if (n == 300) begin
				hold_off_req = 1'b1;
			end
			if (n == 900) begin
				settle();
			end
			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				op = OP_ADD;
			end else if (roll < 70) begin
				op = OP_REMOVE;
			end else if (roll < 75) begin
				op = OP_CLEAR;
			end else begin
				op = OP_FLUSH;
			end
			if ($urandom_range(0, 3) == 0) begin
				a = ADDR_W'($urandom_range(0, 65535));
			end else begin
				a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			offer_word(op, a, 1'b0, '0);
		end

		settle();
		// A flush over a full table is the longest command; any stray word shows up here.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("breakpoint_table_manager verification clean");
		end else begin
			$display("breakpoint_table_manager verification failed");
		end
		$finish;
	end

endmodule
